[hdl/ppl_pkg.sv]
// Package for the packet parameter list parser: payload structs, role and
// phase codes, character constants and the classified-byte record.
// No dependencies.
package ppl_pkg;

   localparam int IDENT_W         = 20;
   localparam int IDENT_MAX       = 999999;
   localparam int MAX_ID_DIGITS_D = 6;
   localparam int QUEUE_DEPTH     = 2;   // power of two, pointers wrap naturally

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CASE_GAP = 8'h20;

   typedef enum logic [2:0] {
      ROLE_DIGIT = 3'd0,
      ROLE_KEY   = 3'd1,
      ROLE_EQ    = 3'd2,
      ROLE_VAL   = 3'd3,
      ROLE_COMMA = 3'd4,
      ROLE_REJ   = 3'd5
   } role_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_IDENT = 2'd1,
      PH_KEY   = 2'd2,
      PH_VALUE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_char;
      role_type           role;
      logic               param_end;
      logic               naked;
      logic               list_done;
      logic               list_valid;
      logic [IDENT_W-1:0] ident;
   } rsp_type;

   // One byte after classification, as it travels from front to back.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       is_comma;
      logic       is_digit;
      logic       is_nz_digit;
      logic       is_letter;
      logic       is_lower;
      logic       is_eq;
      logic       value_bad;
      logic [3:0] digit;
   } cls_type;

endpackage

[hdl/ppl_front.sv]
// Front end of the parameter list parser: accepts bytes and classifies them
// into a registered record for the queue. Depends on ppl_pkg.
module ppl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppl_pkg::req_type req_payload,
   output logic             cls_valid,
   input  logic             cls_ready,
   output ppl_pkg::cls_type cls_item
);
   import ppl_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   cls_type item_ff;
   cls_type item_in;
   logic [7:0] c;

   assign c = req_payload.ch;

   always_comb begin
      item_in.ch          = c;
      item_in.last        = req_payload.last;
      item_in.is_comma    = (c == CH_COMMA);
      item_in.is_digit    = c inside {[8'h30:8'h39]};
      item_in.is_nz_digit = c inside {[8'h31:8'h39]};
      item_in.is_lower    = c inside {[8'h61:8'h7A]};
      item_in.is_letter   = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      item_in.is_eq       = (c == CH_EQ);
      item_in.value_bad   = c inside {CH_EQ, CH_SPACE, CH_COMMA, CH_COLON, CH_LT, CH_NUL};
      // low nibble of an ASCII digit is its value
      item_in.digit       = c[3:0];
   end

   // Stage advances when empty or when the queue takes the held byte.
   assign req_ready = !valid_ff || cls_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_item  = item_ff;

endmodule

[hdl/ppl_queue.sv]
// Short queue between the parser front and back ends.
// Depends on ppl_pkg.
module ppl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ppl_pkg::cls_type push_item,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ppl_pkg::cls_type pop_item
);
   import ppl_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cls_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/ppl_back.sv]
// Back end of the parameter list parser: phase machine, ident accumulator,
// sticky failure flag and the result register. Depends on ppl_pkg.
module ppl_back #(
   parameter int MAX_ID_DIGITS = ppl_pkg::MAX_ID_DIGITS_D
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cls_valid,
   output logic             cls_ready,
   input  ppl_pkg::cls_type cls_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppl_pkg::rsp_type rsp_payload
);
   import ppl_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ID_DIGITS + 1);
   localparam int NEXT_W = IDENT_W + 4;

   phase_type          phase_ff, phase_in, ph_after;
   logic [IDENT_W-1:0] acc_ff, acc_in, acc_after;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               failed_ff, failed_in;
   logic [IDENT_W-1:0] kept_ff, kept_in, kept_after;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               fire;
   logic               ok;
   logic               take;
   logic               is_comma;
   role_type           role;
   logic               good;
   logic               close;
   logic [NEXT_W-1:0]  acc_x;
   logic [NEXT_W-1:0]  next_acc;
   logic               digit_ok;

   assign cls_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = cls_valid && cls_ready;

   // acc * 10 + digit as two shifts and two adds
   assign acc_x    = {4'b0, acc_ff};
   assign next_acc = (acc_x << 3) + (acc_x << 1) + {{(NEXT_W-4){1'b0}}, cls_item.digit};
   assign digit_ok = (cnt_ff < CNT_W'(MAX_ID_DIGITS)) && (next_acc <= NEXT_W'(IDENT_MAX));

   // Classify this byte against the current phase.
   always_comb begin
      ok       = 1'b1;
      take     = 1'b0;
      is_comma = 1'b0;
      role     = ROLE_REJ;
      ph_after = phase_ff;
      if (!failed_ff) begin
         if (cls_item.is_comma) begin
            if (phase_ff == PH_START) begin
               ok = 1'b0;
            end else begin
               role     = ROLE_COMMA;
               is_comma = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (cls_item.is_nz_digit) begin
                     ph_after = PH_IDENT;
                     take     = 1'b1;
                     role     = ROLE_DIGIT;
                  end else if (cls_item.is_letter) begin
                     ph_after = PH_KEY;
                     role     = ROLE_KEY;
                  end else begin
                     ok = 1'b0;
                  end
               end
               PH_IDENT: begin
                  if (cls_item.is_digit) begin
                     take = 1'b1;
                     role = ROLE_DIGIT;
                  end else begin
                     ok = 1'b0;
                  end
               end
               PH_KEY: begin
                  if (cls_item.is_eq) begin
                     ph_after = PH_VALUE;
                     role     = ROLE_EQ;
                  end else if (cls_item.is_letter || cls_item.is_digit) begin
                     role = ROLE_KEY;
                  end else begin
                     ok = 1'b0;
                  end
               end
               default: begin
                  if (cls_item.value_bad) begin
                     ok = 1'b0;
                  end else begin
                     role = ROLE_VAL;
                  end
               end
            endcase
         end
         if (take && !digit_ok) begin
            ok = 1'b0;
         end
         if (!ok) begin
            role = ROLE_REJ;
         end
      end
   end

   assign good       = !failed_ff && ok;
   assign close      = good && (is_comma || cls_item.last);
   assign acc_after  = (good && take) ? next_acc[IDENT_W-1:0] : acc_ff;
   assign kept_after = (close && ph_after == PH_IDENT) ? acc_after : kept_ff;

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      failed_in = failed_ff;
      kept_in   = kept_ff;
      if (fire) begin
         if (cls_item.last) begin
            phase_in  = PH_START;
            acc_in    = '0;
            cnt_in    = '0;
            failed_in = 1'b0;
            kept_in   = '0;
         end else if (!good) begin
            failed_in = 1'b1;
         end else if (close) begin
            phase_in = PH_START;
            acc_in   = '0;
            cnt_in   = '0;
            kept_in  = kept_after;
         end else begin
            phase_in = ph_after;
            acc_in   = acc_after;
            if (take) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // Outputs
   always_comb begin
      rsp_in.out_char   = (good && role == ROLE_KEY && cls_item.is_lower)
                          ? cls_item.ch - CASE_GAP : cls_item.ch;
      rsp_in.role       = role;
      rsp_in.param_end  = close;
      rsp_in.naked      = close && (ph_after == PH_KEY);
      rsp_in.list_done  = cls_item.last;
      rsp_in.list_valid = cls_item.last && good;
      rsp_in.ident      = kept_after;
      rsp_valid_in      = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         failed_ff    <= 1'b0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         failed_ff    <= failed_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/packet_param_list_parser_core.sv]
// Top level of the packet parameter list parser: front classifier, queue
// and back-end phase machine. Depends on ppl_pkg, ppl_front, ppl_queue, ppl_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   req     | in        | req_valid/req_ready  | ppl_pkg::req_type (ch, last)
//   rsp     | out       | rsp_valid/rsp_ready  | ppl_pkg::rsp_type, one per byte
//
// One byte per cycle sustained while rsp_ready stays high; the phase update and the
// ident accumulator (acc * 10 + digit, then a compare with the ident ceiling)
// are combinational in the back end. A byte's result passes through the front
// register, the queue and the result register before it is valid. Synchronous
// reset clears every control register and the parser state. A stalled rsp side
// fills the result register, then the queue, then the front stage, and only
// then drops req_ready.
module packet_param_list_parser_core #(
   parameter int MAX_ID_DIGITS = ppl_pkg::MAX_ID_DIGITS_D
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppl_pkg::rsp_type rsp_payload
);
   import ppl_pkg::*;

   logic    front_valid;
   logic    front_ready;
   cls_type front_item;
   logic    back_valid;
   logic    back_ready;
   cls_type back_item;

   // Accept and classify each byte.
   ppl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cls_valid   (front_valid),
      .cls_ready   (front_ready),
      .cls_item    (front_item)
   );

   // Decouple the two halves so each can stall on its own.
   ppl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // Run the phase machine and hold the result until taken.
   ppl_back #(
      .MAX_ID_DIGITS (MAX_ID_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cls_valid   (back_valid),
      .cls_ready   (back_ready),
      .cls_item    (back_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/ppl_checker.sv]
// Port-level checks for the packet parameter list parser, bound to the top
// level. Depends on ppl_pkg and packet_param_list_parser_core.
module ppl_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ppl_pkg::rsp_type rsp_payload
);
   import ppl_pkg::*;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // A rejected byte never closes a parameter.
   a_rej_no_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.role == ROLE_REJ |-> !rsp_payload.param_end && !rsp_payload.naked)
      else $error("rejected byte closed a parameter");

   // Naked only on a closing byte.
   a_naked_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.naked |-> rsp_payload.param_end)
      else $error("naked without param_end");

   // Validity only on the final byte, and a valid list's final byte closes a parameter.
   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.list_valid |-> rsp_payload.list_done && rsp_payload.param_end)
      else $error("list_valid off the closing final byte");

   // The ident never exceeds its ceiling.
   a_ident_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.ident <= IDENT_W'(IDENT_MAX))
      else $error("ident out of range");

endmodule

bind packet_param_list_parser_core ppl_checker u_ppl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
